// ----- hdl/mdc_pkg.sv -----
package mdc_pkg;

    localparam int unsigned HDR_BYTES         = 32;
    localparam int unsigned HDR_IDX_W         = 5;
    localparam int unsigned CFG_LEN_W         = 12;
    localparam int unsigned CFG_DATA_W        = CFG_LEN_W;
    localparam int unsigned SIZE_W            = 13;
    localparam int unsigned LEN_LIMIT_MAX_DEF = 4095;
    localparam int unsigned CFG_LEN_TOP       = (2 ** CFG_LEN_W) - 1;

    localparam logic [CFG_LEN_W-1:0] MAX_LEN_RESET   = 12'd2048;
    localparam logic [31:0]          POLY_IEEE       = 32'hEDB8_8320;
    localparam logic [31:0]          POLY_CASTAGNOLI = 32'h82F6_3B78;
    localparam logic [31:0]          CRC_INIT        = 32'hFFFF_FFFF;

    localparam logic CFG_MAX_PAYLOAD_LEN = 1'b0;
    localparam logic CFG_CRC_VARIANT     = 1'b1;

    typedef enum logic [1:0] {
        ST_ACCEPTED     = 2'd0,
        ST_CRC_MISMATCH = 2'd1,
        ST_CORRUPT_HDR  = 2'd2
    } t_status;

    typedef struct packed {
        t_status            status;
        logic [31:0]        hdr_type;
        logic [31:0]        stream_offset;
        logic [SIZE_W-1:0]  message_size;
        logic [31:0]        computed_crc;
    } t_result;

    // reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc,
                                             input logic [7:0]  data,
                                             input logic [31:0] poly);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (c[0] ? poly : 32'd0);
        end
        return c;
    endfunction

endpackage

// ----- hdl/message_deframer_crc_check.sv -----
// channel  | direction | handshake                 | payload
// input    | in        | i_in_valid / o_in_ready   | i_data_byte
// result   | out       | o_out_valid / i_out_ready | o_status, o_hdr_type, o_stream_offset,
//          |           |                           | o_message_size, o_computed_crc
// config   | in        | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// One byte per cycle unless a stalled result holds the pipe; a message's result goes
// from its last byte in the input register via the header/CRC stage to the result register.
// The bytewise CRC update between the input and result registers sets the cycle time.
// Synchronous active-low reset; no clearing pass, the block is ready straight after.
// A stalled result only holds the pipe when the next byte would also give a result.
module message_deframer_crc_check #(
    parameter int unsigned LEN_LIMIT_MAX = mdc_pkg::LEN_LIMIT_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [1:0]                      o_status,
    output logic [31:0]                     o_hdr_type,
    output logic [31:0]                     o_stream_offset,
    output logic [mdc_pkg::SIZE_W-1:0]      o_message_size,
    output logic [31:0]                     o_computed_crc,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [mdc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import mdc_pkg::*;

    logic [CFG_LEN_W-1:0] r_max_len;
    logic                 r_crc_variant;

    logic       byte_valid;
    logic [7:0] byte_data;
    logic       advance;
    logic       emit;
    logic       out_free;
    t_result    stage_result;
    t_result    out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len     <= MAX_LEN_RESET;
            r_crc_variant <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MAX_PAYLOAD_LEN: r_max_len     <= i_cfg_data[CFG_LEN_W-1:0];
                CFG_CRC_VARIANT:     r_crc_variant <= i_cfg_data[0];
                default:             r_max_len     <= r_max_len;
            endcase
        end
    end

    assign advance = byte_valid && (!emit || out_free);

    mdc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_data_byte),
        .i_take  (advance),
        .o_ready (o_in_ready),
        .o_valid (byte_valid),
        .o_byte  (byte_data)
    );

    mdc_parser #(
        .LEN_LIMIT_MAX (LEN_LIMIT_MAX)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_byte        (byte_data),
        .i_max_len     (r_max_len),
        .i_crc_variant (r_crc_variant),
        .o_emit        (emit),
        .o_result      (stage_result)
    );

    mdc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && emit),
        .i_result (stage_result),
        .i_ready  (i_out_ready),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_status        = out_result.status;
    assign o_hdr_type      = out_result.hdr_type;
    assign o_stream_offset = out_result.stream_offset;
    assign o_message_size  = out_result.message_size;
    assign o_computed_crc  = out_result.computed_crc;

endmodule

// ----- hdl/mdc_in_reg.sv -----
module mdc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_ready,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ----- hdl/mdc_parser.sv -----
module mdc_parser #(
    parameter int unsigned LEN_LIMIT_MAX = mdc_pkg::LEN_LIMIT_MAX_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_advance,
    input  logic [7:0]                     i_byte,
    input  logic [mdc_pkg::CFG_LEN_W-1:0]  i_max_len,
    input  logic                           i_crc_variant,
    output logic                           o_emit,
    output mdc_pkg::t_result               o_result
);

    import mdc_pkg::*;

    localparam int unsigned LIM_CAP_INT =
        (LEN_LIMIT_MAX < CFG_LEN_TOP) ? LEN_LIMIT_MAX : CFG_LEN_TOP;
    localparam logic [CFG_LEN_W-1:0] LIM_CAP   = CFG_LEN_W'(LIM_CAP_INT);
    localparam logic [HDR_IDX_W-1:0] LAST_IDX  = HDR_IDX_W'(HDR_BYTES - 1);
    localparam logic [SIZE_W-1:0]    HDR_SIZE  = SIZE_W'(HDR_BYTES);

    logic [HDR_IDX_W-1:0] r_hdr_idx,     n_hdr_idx;
    logic                 r_in_payload,  n_in_payload;
    logic [CFG_LEN_W-1:0] r_remaining,   n_remaining;
    logic [31:0]          r_type,        n_type;
    logic [31:0]          r_length,      n_length;
    logic                 r_check_en,    n_check_en;
    logic [31:0]          r_exp_crc,     n_exp_crc;
    logic [31:0]          r_crc,         n_crc;
    logic [31:0]          r_pos,         n_pos;
    logic [31:0]          r_msg_start,   n_msg_start;

    logic [31:0]          crc_step;
    logic [31:0]          crc_final;
    logic [CFG_LEN_W-1:0] rem_dec;
    logic [CFG_LEN_W-1:0] limit;
    logic [4:0]           sh;

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_in_payload = r_in_payload;
        n_remaining  = r_remaining;
        n_type       = r_type;
        n_length     = r_length;
        n_check_en   = r_check_en;
        n_exp_crc    = r_exp_crc;
        n_crc        = r_crc;
        n_msg_start  = r_msg_start;
        n_pos        = r_pos + 32'd1;

        crc_step  = crc_byte(r_crc, i_byte,
                             i_crc_variant ? POLY_CASTAGNOLI : POLY_IEEE);
        crc_final = r_check_en ? ~crc_step : 32'd0;
        rem_dec   = (r_remaining != '0) ? r_remaining - CFG_LEN_W'(1) : r_remaining;
        limit     = (i_max_len > LIM_CAP) ? LIM_CAP : i_max_len;
        sh        = {r_hdr_idx[1:0], 3'b000};

        o_emit                 = 1'b0;
        o_result.status        = ST_ACCEPTED;
        o_result.hdr_type      = r_type;
        o_result.stream_offset = r_msg_start;
        o_result.message_size  = HDR_SIZE + {1'b0, r_length[CFG_LEN_W-1:0]};
        o_result.computed_crc  = 32'd0;

        if (r_in_payload) begin
            if (r_check_en) begin
                n_crc = crc_step;
            end
            n_remaining = rem_dec;
            if (rem_dec == '0) begin
                o_emit                = 1'b1;
                o_result.computed_crc = crc_final;
                if (r_check_en && r_exp_crc != 32'd0 && crc_final != r_exp_crc) begin
                    o_result.status = ST_CRC_MISMATCH;
                end
                n_in_payload = 1'b0;
                n_hdr_idx    = '0;
            end
        end else begin
            if (r_hdr_idx == '0) begin
                n_msg_start = r_pos;
            end
            if (r_hdr_idx < HDR_IDX_W'(4)) begin
                n_type[sh +: 8] = i_byte;
            end else if (r_hdr_idx < HDR_IDX_W'(8)) begin
                n_length[sh +: 8] = i_byte;
            end else if (r_hdr_idx == HDR_IDX_W'(24)) begin
                n_check_en = i_byte[0];
            end else if (r_hdr_idx >= HDR_IDX_W'(28)) begin
                n_exp_crc[sh +: 8] = i_byte;
            end

            if (r_hdr_idx == LAST_IDX) begin
                n_hdr_idx = '0;
                if (r_length == 32'd0 || r_length > {20'd0, limit}) begin
                    o_emit                = 1'b1;
                    o_result.status       = ST_CORRUPT_HDR;
                    o_result.message_size = HDR_SIZE;
                end else begin
                    n_in_payload = 1'b1;
                    n_remaining  = r_length[CFG_LEN_W-1:0];
                    n_crc        = CRC_INIT;
                end
            end else begin
                n_hdr_idx = r_hdr_idx + HDR_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= '0;
            r_in_payload <= 1'b0;
            r_remaining  <= '0;
            r_check_en   <= 1'b0;
            r_crc        <= CRC_INIT;
            r_pos        <= 32'd0;
            r_msg_start  <= 32'd0;
        end else if (i_advance) begin
            r_hdr_idx    <= n_hdr_idx;
            r_in_payload <= n_in_payload;
            r_remaining  <= n_remaining;
            r_check_en   <= n_check_en;
            r_crc        <= n_crc;
            r_pos        <= n_pos;
            r_msg_start  <= n_msg_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_type    <= n_type;
            r_length  <= n_length;
            r_exp_crc <= n_exp_crc;
        end
    end

endmodule

// ----- hdl/mdc_out_reg.sv -----
module mdc_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  mdc_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_free,
    output logic             o_valid,
    output mdc_pkg::t_result o_result
);

    import mdc_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- hdl/mdc_checker.sv -----
module mdc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [1:0]                      o_status,
    input logic [31:0]                     o_hdr_type,
    input logic [31:0]                     o_stream_offset,
    input logic [mdc_pkg::SIZE_W-1:0]      o_message_size,
    input logic [31:0]                     o_computed_crc
);

    import mdc_pkg::*;

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_hdr_type)
            && $stable(o_stream_offset) && $stable(o_message_size)
            && $stable(o_computed_crc) && $stable(o_status))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == ST_ACCEPTED || o_status == ST_CRC_MISMATCH
            || o_status == ST_CORRUPT_HDR)
        else $error("undefined status code");

    a_corrupt_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_CORRUPT_HDR |->
            o_message_size == SIZE_W'(HDR_BYTES) && o_computed_crc == 32'd0)
        else $error("corrupt header result malformed");

    a_msg_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_CORRUPT_HDR |->
            o_message_size > SIZE_W'(HDR_BYTES))
        else $error("message without payload");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

endmodule

bind message_deframer_crc_check mdc_checker u_mdc_checker (.*);

// ----- tb/sv/message_deframer_crc_check_tb.sv -----
module message_deframer_crc_check_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdc_pkg::*;

    localparam int          CLK_PERIOD   = 20;
    localparam int          STALL_LIMIT  = 2000;
    localparam int          DRAIN_CYCLES = 4;
    localparam int unsigned LEN_CAP      = LEN_LIMIT_MAX_DEF;

    typedef enum int {CRC_ZERO, CRC_GOOD, CRC_BAD} crc_field_kind_e;

    class deframe_scoreboard;
        logic [CFG_LEN_W-1:0] len_limit;
        logic                 castagnoli;
        logic [HDR_IDX_W-1:0] hdr_idx;
        logic                 in_body;
        logic [11:0]          body_left;
        logic [31:0]          type_w;
        logic [31:0]          len_w;
        logic [31:0]          hdr_crc;
        logic [31:0]          crc_acc;
        logic [31:0]          byte_pos;
        logic [31:0]          msg_start;
        logic                 crc_on;
        t_result              pending_q[$];
        int                   predicted;
        int                   errors;

        function new();
            len_limit  = MAX_LEN_RESET;
            castagnoli = 1'b0;
            hdr_idx    = '0;
            in_body    = 1'b0;
            body_left  = '0;
            type_w     = '0;
            len_w      = '0;
            hdr_crc    = '0;
            crc_acc    = CRC_INIT;
            byte_pos   = '0;
            msg_start  = '0;
            crc_on     = 1'b0;
            predicted  = 0;
            errors     = 0;
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= 10)
                $display("ERROR @%0t: %s", $realtime, msg);
        endfunction

        function void set_config(logic [CFG_LEN_W-1:0] lim, logic sel_c);
            len_limit  = lim;
            castagnoli = sel_c;
        endfunction

        function logic [31:0] limit_in_force();
            return (len_limit > LEN_CAP) ? LEN_CAP : 32'(len_limit);
        endfunction

        // bit-serial reflected update, LSB of the byte first
        function logic [31:0] crc_update(logic [31:0] c, logic [7:0] b, logic sel_c);
            logic [31:0] poly;
            poly = sel_c ? POLY_CASTAGNOLI : POLY_IEEE;
            for (int i = 0; i < 8; i++)
                c = (c >> 1) ^ ((c[0] ^ b[i]) ? poly : 32'd0);
            return c;
        endfunction

        function void push_result(t_status st, logic [31:0] total, logic [31:0] crc);
            t_result r;
            r.status        = st;
            r.hdr_type      = type_w;
            r.stream_offset = msg_start;
            r.message_size  = total[SIZE_W-1:0];
            r.computed_crc  = crc;
            pending_q.push_back(r);
            predicted++;
        endfunction

        function void note_byte(logic [7:0] b);
            logic [31:0] fin;
            t_status     st;
            if (in_body) begin
                if (crc_on)
                    crc_acc = crc_update(crc_acc, b, castagnoli);
                if (body_left != 0)
                    body_left--;
                if (body_left == 0) begin
                    fin = crc_on ? ~crc_acc : 32'd0;
                    if (crc_on && hdr_crc != 0 && fin != hdr_crc)
                        st = ST_CRC_MISMATCH;
                    else
                        st = ST_ACCEPTED;
                    push_result(st, HDR_BYTES + len_w, fin);
                    in_body = 1'b0;
                    hdr_idx = '0;
                end
            end else begin
                if (hdr_idx == 0) begin
                    msg_start = byte_pos;
                    type_w    = '0;
                    len_w     = '0;
                    hdr_crc   = '0;
                    crc_on    = 1'b0;
                end
                if (hdr_idx < 4)
                    type_w |= 32'(b) << (8 * hdr_idx[1:0]);
                else if (hdr_idx < 8)
                    len_w |= 32'(b) << (8 * hdr_idx[1:0]);
                else if (hdr_idx == 24)
                    crc_on = b[0];
                else if (hdr_idx >= 28)
                    hdr_crc |= 32'(b) << (8 * hdr_idx[1:0]);

                if (hdr_idx == HDR_BYTES - 1) begin
                    hdr_idx = '0;
                    if (len_w == 0 || len_w > limit_in_force()) begin
                        push_result(ST_CORRUPT_HDR, HDR_BYTES, 32'd0);
                    end else begin
                        in_body   = 1'b1;
                        body_left = len_w[11:0];
                        crc_acc   = CRC_INIT;
                    end
                end else begin
                    hdr_idx++;
                end
            end
            byte_pos++;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_q.size() == 0) begin
                fail($sformatf("result with none expected: type %h offset %h",
                               got.hdr_type, got.stream_offset));
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status || got.hdr_type !== want.hdr_type ||
                got.stream_offset !== want.stream_offset ||
                got.message_size !== want.message_size ||
                got.computed_crc !== want.computed_crc)
                fail($sformatf({"mismatch (exp/act): status %0d/%0d type %h/%h ",
                                "offset %h/%h size %0d/%0d crc %h/%h"},
                               want.status, got.status, want.hdr_type, got.hdr_type,
                               want.stream_offset, got.stream_offset,
                               want.message_size, got.message_size,
                               want.computed_crc, got.computed_crc));
        endfunction
    endclass

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [7:0]            i_data_byte    = '0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    logic [1:0]            o_status;
    logic [31:0]           o_hdr_type;
    logic [31:0]           o_stream_offset;
    logic [SIZE_W-1:0]     o_message_size;
    logic [31:0]           o_computed_crc;
    logic                  i_cfg_we       = 1'b0;
    logic                  i_cfg_index    = CFG_MAX_PAYLOAD_LEN;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;

    deframe_scoreboard sb;
    int send_gap_pct   = 11;
    int ready_drop_pct = 61;
    int bytes_fed      = 0;
    int quiet_cycles   = 0;

    message_deframer_crc_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_hdr_type      (o_hdr_type),
        .o_stream_offset (o_stream_offset),
        .o_message_size  (o_message_size),
        .o_computed_crc  (o_computed_crc),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(t_result'{t_status'(o_status), o_hdr_type, o_stream_offset,
                                      o_message_size, o_computed_crc});
        i_out_ready <= ($urandom_range(99) >= ready_drop_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_byte(b);
        bytes_fed++;
    endtask

    // no bytes in flight: results all back, then a drain wait for the pipe
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_LEN_W-1:0] lim, input logic sel_c);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MAX_PAYLOAD_LEN;
        i_cfg_data  <= lim;
        @(posedge i_clk);
        i_cfg_index <= CFG_CRC_VARIANT;
        i_cfg_data  <= CFG_DATA_W'(sel_c);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_config(lim, sel_c);
    endtask

    // pause_at: byte index before which the registers are rewritten
    task automatic send_message(input logic [31:0] typ, input logic [31:0] len,
                                input logic [7:0] flags, input crc_field_kind_e kind,
                                input int pause_at = -1,
                                input logic [CFG_LEN_W-1:0] new_lim = '0,
                                input logic new_sel = 1'b0);
        logic [7:0]  frame[$];
        logic [7:0]  body[$];
        logic [31:0] crc;
        logic [31:0] crc_field;
        logic [31:0] lim;
        logic [7:0]  b;
        crc = CRC_INIT;
        lim = (pause_at >= 0 && pause_at < HDR_BYTES) ? 32'(new_lim) : sb.limit_in_force();
        if (len != 0 && len <= lim) begin
            for (int i = 0; i < len; i++) begin
                b = 8'($urandom);
                body.push_back(b);
                crc = sb.crc_update(crc, b, sb.castagnoli);
            end
        end
        case (kind)
            CRC_ZERO: crc_field = '0;
            CRC_GOOD: crc_field = ~crc;
            default:  crc_field = ~crc ^ ($urandom | 32'd1);
        endcase
        for (int i = 0; i < 4; i++)
            frame.push_back(typ[8*i +: 8]);
        for (int i = 0; i < 4; i++)
            frame.push_back(len[8*i +: 8]);
        repeat (16) frame.push_back(8'($urandom));
        frame.push_back(flags);
        repeat (3) frame.push_back(8'($urandom));
        for (int i = 0; i < 4; i++)
            frame.push_back(crc_field[8*i +: 8]);
        frame = {frame, body};
        foreach (frame[i]) begin
            if (i == pause_at)
                configure(new_lim, new_sel);
            send_byte(frame[i]);
        end
    endtask

    task automatic random_message();
        int unsigned     pick;
        int unsigned     lim;
        logic [7:0]      flags;
        crc_field_kind_e kind;
        pick     = $urandom_range(99);
        lim      = sb.limit_in_force();
        flags    = 8'($urandom);
        flags[0] = ($urandom_range(9) < 7);
        kind     = crc_field_kind_e'($urandom_range(2));
        if (pick < 4) begin
            // raw noise, then pad until the framing lines up again
            repeat ($urandom_range(1, 40)) send_byte(8'($urandom));
            while (sb.hdr_idx != 0 || sb.in_body)
                send_byte(8'($urandom));
        end else if (pick < 8) begin
            send_message($urandom, $urandom, flags, kind);
        end else if (pick < 12) begin
            send_message($urandom, 32'd0, flags, kind);
        end else if (pick < 16) begin
            send_message($urandom, lim + $urandom_range(1, 8), flags, kind);
        end else if (pick < 19) begin
            send_message($urandom, $urandom_range(1, lim), flags, kind);
        end else if (pick < 24) begin
            send_message($urandom, lim, flags, kind);
        end else begin
            send_message($urandom, $urandom_range(1, (lim < 24) ? lim : 24), flags, kind);
        end
    endtask

    task automatic run_phase(input int gap_pct, input int drop_pct,
                             input logic [CFG_LEN_W-1:0] lim, input logic sel_c);
        int first_byte;
        int first_result;
        configure(lim, sel_c);
        send_gap_pct   = gap_pct;
        ready_drop_pct = drop_pct;
        first_byte     = bytes_fed;
        first_result   = sb.predicted;
        while (bytes_fed - first_byte < 100 || sb.predicted - first_result < 2)
            random_message();
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: limit 2048, IEEE
        send_message(32'hFFFF_FFFF, 32'd1, 8'h00, CRC_GOOD);
        send_message(32'h0000_0000, 32'd0, 8'h01, CRC_GOOD);
        send_message(32'h1234_5678, 32'd3, 8'hFF, CRC_GOOD);
        send_message(32'h8000_0001, 32'd5, 8'h01, CRC_ZERO);
        send_message(32'h5A5A_A5A5, 32'd4, 8'h01, CRC_BAD);
        send_message(32'hDEAD_BEEF, 32'd7, 8'hFE, CRC_BAD);
        send_message(32'h0000_0001, 32'd2049, 8'h01, CRC_GOOD);
        send_message(32'h0000_0002, 32'h0100_0001, 8'h01, CRC_GOOD);
        send_message(32'h0000_0003, 32'd2, 8'h01, CRC_GOOD);

        configure(12'd0, 1'b1);
        send_message(32'h0000_0004, 32'd1, 8'h01, CRC_GOOD);

        configure(12'd4095, 1'b1);
        send_message(32'h0000_0005, 32'd8, 8'h01, CRC_GOOD);
        send_message(32'h0000_0006, 32'd4096, 8'h01, CRC_GOOD);

        configure(12'd1, 1'b0);
        send_message(32'h0000_0007, 32'd1, 8'h01, CRC_GOOD);
        send_message(32'h0000_0008, 32'd2, 8'h01, CRC_GOOD);

        // limit raised partway through the header, then variant flipped mid-payload
        send_message(32'h0000_0009, 32'd9, 8'h01, CRC_GOOD, 20, 12'd16, 1'b0);
        send_message(32'h0000_000A, 32'd6, 8'h01, CRC_GOOD, 34, 12'd16, 1'b1);

        run_phase(11, 61, 12'd48, 1'b0);
        run_phase(61, 11, 12'($urandom_range(1, 64)), 1'b1);
        run_phase(0, 0, 12'($urandom_range(16, 64)), 1'($urandom_range(1)));

        wait_idle();
        if (sb.pending_q.size() != 0)
            sb.fail($sformatf("%0d expected results never arrived", sb.pending_q.size()));
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
